// ===== hw/rtl/rpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_pkg
// Shared types, constants and helpers of the RGB pixel blend unit.
// ----------------------------------------------------------------------------
package rpba_pkg;

    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = 9;
    localparam int NUM_CH  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_MULT   = 2'd2,
        MODE_SCREEN = 2'd3
    } t_blend_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE  = 2'd0,
        REG_ALPHA_LEVEL = 2'd1
    } t_cfg_reg;

    // floor(p / 255) for p up to 255 * 255, as (p * 257 + 257) >> 16.
    function automatic t_chan div255(input logic [2*CHAN_W-1:0] p);
        logic [24:0] t;
        t = {9'd0, p} + {1'b0, p, 8'd0} + 25'd257;
        return t[23:16];
    endfunction

endpackage

// ===== hw/rtl/rpba_blend_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_blend_chan
// Two-stage blend of one color channel: product or saturating sum first,
// then the scale by 1/255 and the mode select.
// ----------------------------------------------------------------------------
module rpba_blend_chan (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  rpba_pkg::t_blend_mode    i_mode,
    input  rpba_pkg::t_chan          i_dest,
    input  rpba_pkg::t_chan          i_src,
    output rpba_pkg::t_chan          o_dest,
    output rpba_pkg::t_chan          o_blend
);

    rpba_pkg::t_chan         n_op_a;
    rpba_pkg::t_chan         n_op_b;
    logic [8:0]              n_sum;
    rpba_pkg::t_chan         n_sat;
    rpba_pkg::t_chan         n_blend;

    logic [15:0]             r_prod;
    rpba_pkg::t_chan         r_sat;
    rpba_pkg::t_chan         r_src1;
    rpba_pkg::t_chan         r_dest1;
    rpba_pkg::t_blend_mode   r_mode1;
    rpba_pkg::t_chan         r_dest2;
    rpba_pkg::t_chan         r_blend;

    always_comb begin
        // Screen works on the complements, which for 8 bits is 255 - x.
        if (i_mode == rpba_pkg::MODE_SCREEN) begin
            n_op_a = ~i_dest;
            n_op_b = ~i_src;
        end else begin
            n_op_a = i_dest;
            n_op_b = i_src;
        end
        n_sum = {1'b0, i_dest} + {1'b0, i_src};
        n_sat = n_sum[8] ? rpba_pkg::CHAN_MAX : n_sum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod  <= n_op_a * n_op_b;
            r_sat   <= n_sat;
            r_src1  <= i_src;
            r_dest1 <= i_dest;
            r_mode1 <= i_mode;
        end
    end

    always_comb begin
        case (r_mode1)
            rpba_pkg::MODE_NORMAL: n_blend = r_src1;
            rpba_pkg::MODE_ADD:    n_blend = r_sat;
            rpba_pkg::MODE_MULT:   n_blend = rpba_pkg::div255(r_prod);
            rpba_pkg::MODE_SCREEN: n_blend = ~rpba_pkg::div255(r_prod);
            default:               n_blend = r_src1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_blend <= n_blend;
            r_dest2 <= r_dest1;
        end
    end

    assign o_dest  = r_dest2;
    assign o_blend = r_blend;

endmodule

// ===== hw/rtl/rpba_mix_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_mix_chan
// Two-stage alpha mix of one channel: weighted products, then sum and select.
// ----------------------------------------------------------------------------
module rpba_mix_chan (
    input  logic                           i_clk,
    input  logic                           i_ce,
    input  logic [rpba_pkg::ALPHA_W-1:0]   i_alpha,
    input  rpba_pkg::t_chan                i_dest,
    input  rpba_pkg::t_chan                i_blend,
    output rpba_pkg::t_chan                o_out
);

    logic [rpba_pkg::ALPHA_W-1:0] n_inv;
    logic [16:0]                  n_total;
    rpba_pkg::t_chan              n_out;

    logic [15:0]                  r_pb;
    logic [16:0]                  r_pd;
    logic                         r_full;
    logic                         r_zero;
    rpba_pkg::t_chan              r_b;
    rpba_pkg::t_chan              r_d;
    rpba_pkg::t_chan              r_out;

    assign n_inv = rpba_pkg::ALPHA_ONE - i_alpha;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // The products are only used when alpha lies in 1..255.
            r_pb   <= i_blend * i_alpha[7:0];
            r_pd   <= i_dest * n_inv;
            r_full <= i_alpha[8];
            r_zero <= (i_alpha == '0);
            r_b    <= i_blend;
            r_d    <= i_dest;
        end
    end

    always_comb begin
        n_total = {1'b0, r_pb} + r_pd;
        if (r_full) begin
            n_out = r_b;
        end else if (r_zero) begin
            n_out = r_d;
        end else begin
            n_out = n_total[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// ===== hw/rtl/rgb_pixel_blend_with_alpha_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_blend_with_alpha_unit
// RGB888 compositor: per-channel blend mode followed by an alpha mix.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock and passes it through four register
// stages: a multiply stage, a 1/255 scale and mode select stage, an alpha
// product stage, and a sum stage that also serves as the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a full pipe sustains one pixel per clock. Blend mode and
// alpha are written through the configuration channel, which is always ready;
// write them only while no pixel is in flight.
module rgb_pixel_blend_with_alpha_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input request.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // dest_red, dest_green, dest_blue, src_red, src_green, src_blue
    input  logic [47:0] i_s_axis_tdata,
    // Pixel result.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] o_m_axis_tdata,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rpba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpba_pkg::ALPHA_W-1:0]      i_cfg_data
);

    localparam int DEPTH = 4;

    rpba_pkg::t_blend_mode            r_mode;
    logic [rpba_pkg::ALPHA_W-1:0]     r_alpha;
    logic [DEPTH-1:0]                 r_vld;
    logic                             n_ce;

    rpba_pkg::t_chan dest_c  [rpba_pkg::NUM_CH];
    rpba_pkg::t_chan src_c   [rpba_pkg::NUM_CH];
    rpba_pkg::t_chan dest_b  [rpba_pkg::NUM_CH];
    rpba_pkg::t_chan blend_b [rpba_pkg::NUM_CH];
    rpba_pkg::t_chan out_c   [rpba_pkg::NUM_CH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rpba_pkg::MODE_NORMAL;
            r_alpha <= rpba_pkg::ALPHA_ONE;
        end else if (i_cfg_valid) begin
            case (rpba_pkg::t_cfg_reg'(i_cfg_index))
                rpba_pkg::REG_BLEND_MODE:
                    r_mode <= rpba_pkg::t_blend_mode'(i_cfg_data[1:0]);
                rpba_pkg::REG_ALPHA_LEVEL:
                    r_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Everything moves when the output register can take a new pixel.
    assign n_ce            = !r_vld[DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = n_ce;
    assign o_m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_ce) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    for (genvar c = 0; c < rpba_pkg::NUM_CH; c++) begin : g_chan
        assign dest_c[c] = i_s_axis_tdata[c*rpba_pkg::CHAN_W +: rpba_pkg::CHAN_W];
        assign src_c[c]  =
            i_s_axis_tdata[(c+rpba_pkg::NUM_CH)*rpba_pkg::CHAN_W +: rpba_pkg::CHAN_W];

        rpba_blend_chan u_blend (
            .i_clk   (i_clk),
            .i_ce    (n_ce),
            .i_mode  (r_mode),
            .i_dest  (dest_c[c]),
            .i_src   (src_c[c]),
            .o_dest  (dest_b[c]),
            .o_blend (blend_b[c])
        );

        rpba_mix_chan u_mix (
            .i_clk   (i_clk),
            .i_ce    (n_ce),
            .i_alpha (r_alpha),
            .i_dest  (dest_b[c]),
            .i_blend (blend_b[c]),
            .o_out   (out_c[c])
        );

        assign o_m_axis_tdata[c*rpba_pkg::CHAN_W +: rpba_pkg::CHAN_W] = out_c[c];
    end

endmodule
